// ===== sv/arwc_pkg.sv =====
`default_nettype none
package arwc_pkg;

	// shared adder width: covers bw * mss^2 * |f| plus the Winc offset
	localparam int AW = 88;
	// remainder and divisor width
	localparam int DW = 64;
	// step counter width
	localparam int CW = 7;

	localparam logic [28:0] WINC_SCALE = 29'd524288000;
	localparam logic [13:0] K1_Q16     = 14'd13101;
	localparam logic [17:0] K2_Q16     = 18'd13104;
	localparam logic [15:0] EWMA_OLD   = 16'd55706;
	localparam logic [15:0] EWMA_NEW   = 16'd9830;
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [13:0] MSS_RESET  = 14'd536;

	localparam logic [1:0] REQ_RTT  = 2'd0;
	localparam logic [1:0] REQ_ACK  = 2'd1;
	localparam logic [1:0] REQ_LOSS = 2'd2;
	localparam logic [1:0] REQ_NOP  = 2'd3;

	localparam logic REG_MSS = 1'b0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [23:0] rtt_us;
		logic [15:0] segments_acked;
		logic [31:0] current_window;
		logic [39:0] bandwidth_estimate;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] new_window;
		logic [31:0] slow_start_threshold;
		logic [16:0] congestion_level;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RTT, S_EW_INIT, S_EW_MUL1, S_EW_SET2, S_EW_MUL2, S_EW_END,
		S_LVL_SET, S_LVL_DIV, S_LVL_END,
		S_SQ_SET, S_SQ_MUL, S_AD_SET, S_AD_DIV, S_AD_END,
		S_DV_SET, S_DV_MUL, S_P1_SET, S_P1_MUL, S_P2_SET, S_P2_MUL,
		S_WINC, S_WSUB2, S_Q_SET, S_Q_DIV, S_Q_END,
		S_LS_SET, S_LS_DIV, S_LS_END, S_DONE
	} st_t;

	// one entry of the exp(-10c) table: r^i in Q.31, rounded to Q0.16
	function automatic logic [15:0] exp_entry(logic [63:0] r, int unsigned i);
		logic [63:0] p;
		logic [63:0] v;
		p = 64'd1 << 31;
		for (int unsigned k = 0; k < i; k++) begin
			p = (p * r) >> 31;
		end
		v = (p + (64'd1 << 14)) >> 15;
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/adaptive_reno_window_control.sv =====
`default_nettype none
// Adaptive Reno congestion window controller for one connection. Each request beat
// (RTT sample, congestion-avoidance ack, loss or unused kind) yields exactly one
// response beat with the window base+probe, the slow start threshold (nonzero on
// loss only) and the congestion level in Q1.16. The shift-and-add multiplies and
// the divides run one bit per cycle through a single shared adder/subtractor, so
// the block takes one request at a time. An RTT sample, a zero-segment ack or an
// unused kind runs at most the congestion-level division (RTT_BITS+16 steps,
// skipped when the level is plainly zero or one); a loss adds up to two 16-step
// EWMA multiplies before it and the 48-step window division after it; an ack with
// segments also runs the square, the adder division, three products and the
// 88-step probe division. The response sits in an output register, so a new
// request is taken while it waits; a finished request holds until that register is free.
module adaptive_reno_window_control #(
	parameter int EXP_ENTRIES = 256,
	parameter int RTT_BITS    = 24
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire arwc_pkg::req_t in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output arwc_pkg::rsp_t      out_data
);
	import arwc_pkg::*;

	localparam int IW = $clog2(EXP_ENTRIES);

	// exp table series, worked out at elaboration
	localparam logic [63:0] X   = (64'd10 << 31) / (EXP_ENTRIES - 1);
	localparam logic [63:0] T0  = 64'd1 << 31;
	localparam logic [63:0] T1  = ((T0 * X) >> 31) / 1;
	localparam logic [63:0] T2  = ((T1 * X) >> 31) / 2;
	localparam logic [63:0] T3  = ((T2 * X) >> 31) / 3;
	localparam logic [63:0] T4  = ((T3 * X) >> 31) / 4;
	localparam logic [63:0] T5  = ((T4 * X) >> 31) / 5;
	localparam logic [63:0] T6  = ((T5 * X) >> 31) / 6;
	localparam logic [63:0] T7  = ((T6 * X) >> 31) / 7;
	localparam logic [63:0] T8  = ((T7 * X) >> 31) / 8;
	localparam logic [63:0] T9  = ((T8 * X) >> 31) / 9;
	localparam logic [63:0] T10 = ((T9 * X) >> 31) / 10;
	localparam logic [63:0] T11 = ((T10 * X) >> 31) / 11;
	localparam logic [63:0] T12 = ((T11 * X) >> 31) / 12;
	localparam logic [63:0] T13 = ((T12 * X) >> 31) / 13;
	localparam logic [63:0] T14 = ((T13 * X) >> 31) / 14;
	localparam logic [63:0] T15 = ((T14 * X) >> 31) / 15;
	localparam logic [63:0] T16 = ((T15 * X) >> 31) / 16;
	localparam logic [63:0] T17 = ((T16 * X) >> 31) / 17;
	localparam logic [63:0] T18 = ((T17 * X) >> 31) / 18;
	localparam logic [63:0] T19 = ((T18 * X) >> 31) / 19;
	localparam logic [63:0] T20 = ((T19 * X) >> 31) / 20;
	localparam logic [63:0] T21 = ((T20 * X) >> 31) / 21;
	localparam logic [63:0] T22 = ((T21 * X) >> 31) / 22;
	localparam logic [63:0] T23 = ((T22 * X) >> 31) / 23;
	localparam logic [63:0] T24 = ((T23 * X) >> 31) / 24;
	localparam logic [63:0] S_SUM = T0 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9
		+ T10 + T11 + T12 + T13 + T14 + T15 + T16 + T17 + T18 + T19 + T20 + T21
		+ T22 + T23 + T24;
	localparam logic [63:0] R_STEP = (64'd1 << 62) / S_SUM;

	logic [15:0] exp_tab [EXP_ENTRIES];
	for (genvar g = 0; g < EXP_ENTRIES; g++) begin : g_tab
		localparam logic [15:0] V = exp_entry(R_STEP, g);
		assign exp_tab[g] = V;
	end

	st_t state_q, state_d;

	logic [13:0]          mss_q;
	logic [RTT_BITS-1:0]  min_rtt_q, lat_rtt_q, cg_rtt_q;
	logic [31:0]          base_q, probe_q;

	logic [1:0]           kind_q;
	logic [RTT_BITS-1:0]  rtt_q;
	logic                 segs_nz_q;
	logic [31:0]          cwnd_q, w_q;
	logic [39:0]          bw_q;

	logic [AW-1:0]        acc_q, mcand_q;
	logic [31:0]          mplier_q;
	logic [DW-1:0]        rem_q, dvs_q;
	logic [CW-1:0]        cnt_q;
	logic [16:0]          c_q;
	logic [IW-1:0]        idx_q;
	logic [16:0]          fmag_q;
	logic                 fneg_q, neg_q;
	logic [27:0]          mss2_q;
	logic [31:0]          ssth_q;
	logic                 out_valid_q;
	rsp_t                 out_data_q;

	// shared adder/subtractor
	logic [AW-1:0]  alu_x, alu_y;
	logic           alu_sub;
	logic [AW:0]    alu_res;
	logic           alu_c;
	logic [DW-1:0]  rem_sh;

	assign rem_sh = {rem_q[DW-2:0], acc_q[AW-1]};

	always_comb begin
		alu_x   = acc_q;
		alu_y   = mcand_q;
		alu_sub = 1'b0;
		case (state_q)
			S_LVL_DIV, S_AD_DIV, S_Q_DIV, S_LS_DIV: begin
				alu_x   = AW'(rem_sh);
				alu_y   = AW'(dvs_q);
				alu_sub = 1'b1;
			end
			S_WINC: begin
				if (fneg_q) begin
					alu_x   = AW'(WINC_SCALE);
					alu_y   = acc_q;
					alu_sub = 1'b1;
				end else begin
					alu_y = AW'(WINC_SCALE);
				end
			end
			S_WSUB2: begin
				alu_y   = AW'(WINC_SCALE);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign alu_res = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + (AW+1)'(alu_sub);
	assign alu_c   = alu_res[AW];

	// request decode
	logic                in_fire, out_fire, done_fire;
	logic [31:0]         rtt_ext;
	logic [RTT_BITS-1:0] rtt_in;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign rtt_ext   = {8'd0, in_data.rtt_us};
	assign rtt_in    = rtt_ext[RTT_BITS-1:0];

	// side results
	logic [31:0]  idx_wide;
	logic [30:0]  k1_prod;
	logic [17:0]  f_val;
	logic [28:0]  adder;
	logic [32:0]  base_sum;
	logic [31:0]  base_src;
	logic [32:0]  probe_sum;
	logic [AW-1:0] q_up;
	logic [31:0]  floor_th, loss_base;
	logic [32:0]  win_sum;
	logic [RTT_BITS+15:0] lvl_q;
	logic         pay_d;

	assign idx_wide  = (32'(c_q) * 32'(EXP_ENTRIES - 1) + 32'd32768) >> 16;
	assign k1_prod   = 31'(c_q) * 31'(K1_Q16);
	assign f_val     = 18'(exp_tab[idx_q]) + 18'(k1_prod[30:16]) - K2_Q16;
	assign adder     = (acc_q[27:0] == 28'd0) ? 29'd1 : {1'b0, acc_q[27:0]};
	assign base_src  = (base_q == 32'd0) ? cwnd_q : base_q;
	assign base_sum  = {1'b0, base_src} + 33'(adder);
	assign probe_sum = {1'b0, probe_q} + {1'b0, acc_q[31:0]};
	assign q_up      = acc_q + AW'(rem_q != '0);
	assign floor_th  = {17'd0, mss_q, 1'b0};
	assign loss_base = acc_q[31:0];
	assign win_sum   = {1'b0, base_q} + {1'b0, probe_q};
	assign lvl_q     = acc_q[RTT_BITS+15:0];
	assign pay_d     = kind_q == REQ_ACK && segs_nz_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (in_data.req_type)
						REQ_RTT:  state_d = S_RTT;
						REQ_LOSS: state_d = S_EW_INIT;
						default:  state_d = S_LVL_SET;
					endcase
				end
			end
			S_RTT:     state_d = S_LVL_SET;
			S_EW_INIT: state_d = (cg_rtt_q == '0) ? S_LVL_SET : S_EW_MUL1;
			S_EW_MUL1: if (cnt_q == CW'(1)) state_d = S_EW_SET2;
			S_EW_SET2: state_d = S_EW_MUL2;
			S_EW_MUL2: if (cnt_q == CW'(1)) state_d = S_EW_END;
			S_EW_END:  state_d = S_LVL_SET;
			S_LVL_SET: begin
				if (lat_rtt_q > min_rtt_q && cg_rtt_q > min_rtt_q) begin
					state_d = S_LVL_DIV;
				end else if (kind_q == REQ_LOSS) begin
					state_d = S_LS_SET;
				end else if (pay_d) begin
					state_d = S_SQ_SET;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LVL_DIV: if (cnt_q == CW'(1)) state_d = S_LVL_END;
			S_LVL_END: begin
				if (kind_q == REQ_LOSS) state_d = S_LS_SET;
				else if (pay_d)         state_d = S_SQ_SET;
				else                    state_d = S_DONE;
			end
			S_SQ_SET:  state_d = S_SQ_MUL;
			S_SQ_MUL:  if (cnt_q == CW'(1)) state_d = S_AD_SET;
			S_AD_SET:  state_d = S_AD_DIV;
			S_AD_DIV:  if (cnt_q == CW'(1)) state_d = S_AD_END;
			S_AD_END:  state_d = S_DV_SET;
			S_DV_SET:  state_d = S_DV_MUL;
			S_DV_MUL:  if (cnt_q == CW'(1)) state_d = S_P1_SET;
			S_P1_SET:  state_d = S_P1_MUL;
			S_P1_MUL:  if (cnt_q == CW'(1)) state_d = S_P2_SET;
			S_P2_SET:  state_d = S_P2_MUL;
			S_P2_MUL:  if (cnt_q == CW'(1)) state_d = S_WINC;
			S_WINC:    state_d = (fneg_q && !alu_c) ? S_WSUB2 : S_Q_SET;
			S_WSUB2:   state_d = S_Q_SET;
			S_Q_SET:   state_d = S_Q_DIV;
			S_Q_DIV:   if (cnt_q == CW'(1)) state_d = S_Q_END;
			S_Q_END:   state_d = S_DONE;
			S_LS_SET:  state_d = S_LS_DIV;
			S_LS_DIV:  if (cnt_q == CW'(1)) state_d = S_LS_END;
			S_LS_END:  state_d = S_DONE;
			S_DONE:    if (done_fire) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mss_q       <= MSS_RESET;
			min_rtt_q   <= '0;
			lat_rtt_q   <= '0;
			cg_rtt_q    <= '0;
			base_q      <= '0;
			probe_q     <= '0;
		end else begin
			state_q <= state_d;
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite && paddr[2] == REG_MSS) begin
				mss_q <= pwdata[13:0];
			end
			case (state_q)
				S_RTT: begin
					if (rtt_q != '0) begin
						lat_rtt_q <= rtt_q;
						if (min_rtt_q == '0 || min_rtt_q > rtt_q) min_rtt_q <= rtt_q;
					end
				end
				S_EW_INIT: if (cg_rtt_q == '0) cg_rtt_q <= lat_rtt_q;
				S_EW_END:  cg_rtt_q <= acc_q[RTT_BITS+15:16];
				S_AD_END:  base_q <= base_sum[32] ? 32'hFFFF_FFFF : base_sum[31:0];
				S_Q_END: begin
					if (!neg_q) begin
						if (|acc_q[AW-1:32] || probe_sum[32]) probe_q <= 32'hFFFF_FFFF;
						else                                    probe_q <= probe_sum[31:0];
					end else begin
						if (|q_up[AW-1:32] || q_up[31:0] >= probe_q) probe_q <= '0;
						else                                        probe_q <= probe_q - q_up[31:0];
					end
				end
				S_LS_END: begin
					base_q  <= loss_base;
					probe_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q    <= in_data.req_type;
			rtt_q     <= rtt_in;
			segs_nz_q <= in_data.segments_acked != 16'd0;
			cwnd_q    <= in_data.current_window;
			w_q       <= (in_data.current_window == 32'd0) ? 32'd1 : in_data.current_window;
			bw_q      <= in_data.bandwidth_estimate;
			ssth_q    <= '0;
		end
		if (done_fire) begin
			out_data_q.event_kind           <= kind_q;
			out_data_q.new_window           <= win_sum[32] ? 32'hFFFF_FFFF : win_sum[31:0];
			out_data_q.slow_start_threshold <= ssth_q;
			out_data_q.congestion_level     <= c_q;
		end
		case (state_q)
			S_EW_INIT: begin
				acc_q    <= AW'(32768);
				mcand_q  <= AW'(cg_rtt_q);
				mplier_q <= 32'(EWMA_OLD);
				cnt_q    <= CW'(16);
			end
			S_EW_SET2: begin
				mcand_q  <= AW'(lat_rtt_q);
				mplier_q <= 32'(EWMA_NEW);
				cnt_q    <= CW'(16);
			end
			S_EW_MUL1, S_EW_MUL2, S_SQ_MUL, S_DV_MUL, S_P1_MUL, S_P2_MUL: begin
				if (mplier_q[0]) acc_q <= alu_res[AW-1:0];
				mcand_q  <= {mcand_q[AW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[31:1]};
				cnt_q    <= cnt_q - CW'(1);
			end
			S_LVL_SET: begin
				if (lat_rtt_q <= min_rtt_q) begin
					c_q <= '0;
				end else if (cg_rtt_q <= min_rtt_q) begin
					c_q <= ONE_Q16;
				end else begin
					acc_q <= {lat_rtt_q - min_rtt_q, {(AW-RTT_BITS){1'b0}}};
					dvs_q <= DW'(cg_rtt_q - min_rtt_q);
					rem_q <= '0;
					cnt_q <= CW'(RTT_BITS + 16);
				end
			end
			S_LVL_DIV, S_AD_DIV, S_Q_DIV, S_LS_DIV: begin
				rem_q <= alu_c ? alu_res[DW-1:0] : rem_sh;
				acc_q <= {acc_q[AW-2:0], alu_c};
				cnt_q <= cnt_q - CW'(1);
			end
			S_LVL_END: begin
				c_q <= (lvl_q > (RTT_BITS+16)'(ONE_Q16)) ? ONE_Q16 : lvl_q[16:0];
			end
			S_SQ_SET: begin
				acc_q    <= '0;
				mcand_q  <= AW'(mss_q);
				mplier_q <= 32'(mss_q);
				cnt_q    <= CW'(14);
				idx_q    <= idx_wide[IW-1:0];
			end
			S_AD_SET: begin
				mss2_q <= acc_q[27:0];
				acc_q  <= {acc_q[27:0], {(AW-28){1'b0}}};
				dvs_q  <= DW'(w_q);
				rem_q  <= '0;
				cnt_q  <= CW'(28);
				fneg_q <= f_val[17];
				fmag_q <= f_val[17] ? 17'(-f_val) : f_val[16:0];
			end
			S_DV_SET: begin
				acc_q    <= '0;
				mcand_q  <= AW'(WINC_SCALE);
				mplier_q <= w_q;
				cnt_q    <= CW'(32);
			end
			S_P1_SET: begin
				dvs_q    <= acc_q[DW-1:0];
				acc_q    <= '0;
				mcand_q  <= AW'(bw_q);
				mplier_q <= 32'(mss2_q);
				cnt_q    <= CW'(28);
			end
			S_P2_SET: begin
				mcand_q  <= acc_q;
				acc_q    <= '0;
				mplier_q <= 32'(fmag_q);
				cnt_q    <= CW'(17);
			end
			S_WINC: begin
				neg_q <= 1'b0;
				if (!fneg_q || alu_c) acc_q <= alu_res[AW-1:0];
			end
			S_WSUB2: begin
				acc_q <= alu_res[AW-1:0];
				neg_q <= 1'b1;
			end
			S_Q_SET: begin
				rem_q <= '0;
				cnt_q <= CW'(AW);
			end
			S_LS_SET: begin
				acc_q <= {cwnd_q, 16'd0, {(AW-48){1'b0}}};
				dvs_q <= DW'({1'b0, ONE_Q16} + 18'(c_q));
				rem_q <= '0;
				cnt_q <= CW'(48);
			end
			S_LS_END: begin
				ssth_q <= (loss_base > floor_th) ? loss_base : floor_th;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_MSS) ? {18'd0, mss_q} : 32'd0;

	// busy after a request until its response is produced
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("request taken while busy");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.congestion_level <= ONE_Q16)
		else $error("congestion level above one");

	a_ssth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind != REQ_LOSS |-> out_data.slow_start_threshold == 32'd0)
		else $error("threshold on non-loss response");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("response overwritten");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
	import arwc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	req_t        in_data;
	logic        out_valid;
	logic        out_ready;
	rsp_t        out_data;

	adaptive_reno_window_control uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// window model state
	logic [15:0] exp_rom [256];
	logic [13:0] mdl_mss;
	logic [23:0] mdl_min_rtt, mdl_cur_rtt, mdl_cong_rtt;
	logic [31:0] mdl_base, mdl_probe;

	req_t pend_req[$];
	rsp_t window_exp[$];
	int   mismatches;
	bit   in_fired;
	bit   calm;
	int   hold_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void build_exp_rom();
		logic [63:0] x, term, sum, r, p, v;
		x = (64'd10 << 31) / 64'd255;
		term = 64'd1 << 31;
		sum = term;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * x) >> 31) / k;
			sum += term;
		end
		r = (64'd1 << 62) / sum;
		p = 64'd1 << 31;
		for (int i = 0; i < 256; i++) begin
			v = (p + (64'd1 << 14)) >> 15;
			exp_rom[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			p = (p * r) >> 31;
		end
	endfunction

	function automatic logic [16:0] cong_level();
		logic [63:0] q;
		if (mdl_cur_rtt <= mdl_min_rtt) return 17'd0;
		if (mdl_cong_rtt <= mdl_min_rtt) return ONE_Q16;
		q = ({40'd0, mdl_cur_rtt - mdl_min_rtt} << 16) / {40'd0, mdl_cong_rtt - mdl_min_rtt};
		return (q > 64'd65536) ? ONE_Q16 : q[16:0];
	endfunction

	function automatic logic [31:0] sat32(logic [127:0] v);
		return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic void grow_window(logic [31:0] cwnd, logic [39:0] bw);
		logic [63:0]  w, mss2, adder, c, idx, mag, d, q;
		longint       f;
		logic [127:0] prod, num, q128;
		bit           neg, rem_nz;
		w = (cwnd == 0) ? 64'd1 : {32'd0, cwnd};
		mss2 = {50'd0, mdl_mss} * {50'd0, mdl_mss};
		adder = mss2 / w;
		if (adder < 1) adder = 1;
		if (mdl_base == 0) mdl_base = cwnd;
		mdl_base = sat32({96'd0, mdl_base} + {64'd0, adder});
		c = {47'd0, cong_level()};
		idx = (c * 255 + 64'd32768) >> 16;
		if (idx > 255) idx = 255;
		f = longint'(exp_rom[idx]) + longint'((c * 13101) >> 16) - 13104;
		mag = (f < 0) ? 64'(-f) : 64'(f);
		prod = {88'd0, bw} * {64'd0, mss2} * {64'd0, mag};
		neg = 1'b0;
		if (f >= 0) begin
			num = prod + WINC_SCALE;
		end else if (prod <= WINC_SCALE) begin
			num = WINC_SCALE - prod;
		end else begin
			num = prod - WINC_SCALE;
			neg = 1'b1;
		end
		d = 64'(WINC_SCALE) * w;
		q128 = num / {64'd0, d};
		rem_nz = (num % {64'd0, d}) != 0;
		q = (q128 >> 64 != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q128[63:0];
		if (!neg) begin
			mdl_probe = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sat32({64'd0, mdl_probe} + q);
		end else begin
			if (rem_nz && q != 64'hFFFF_FFFF_FFFF_FFFF) q++;
			mdl_probe = (q >= mdl_probe) ? 32'd0 : mdl_probe - q[31:0];
		end
	endfunction

	function automatic rsp_t predict_window(req_t r);
		rsp_t        e;
		logic [31:0] thr, floor_th;
		logic [63:0] ew;
		logic [16:0] c;
		thr = 32'd0;
		case (r.req_type)
			REQ_RTT: begin
				if (r.rtt_us != 0) begin
					mdl_cur_rtt = r.rtt_us;
					if (mdl_min_rtt == 0 || mdl_min_rtt > r.rtt_us) mdl_min_rtt = r.rtt_us;
				end
			end
			REQ_ACK: begin
				if (r.segments_acked != 0) grow_window(r.current_window, r.bandwidth_estimate);
			end
			REQ_LOSS: begin
				floor_th = {17'd0, mdl_mss, 1'b0};
				if (mdl_cong_rtt == 0) begin
					mdl_cong_rtt = mdl_cur_rtt;
				end else begin
					ew = (64'(EWMA_OLD) * mdl_cong_rtt + 64'(EWMA_NEW) * mdl_cur_rtt
						+ 64'd32768) >> 16;
					mdl_cong_rtt = ew[23:0];
				end
				c = cong_level();
				ew = ({32'd0, r.current_window} << 16) / (64'd65536 + c);
				mdl_base = ew[31:0];
				mdl_probe = 32'd0;
				thr = (mdl_base > floor_th) ? mdl_base : floor_th;
			end
			default: ;
		endcase
		e.event_kind = r.req_type;
		e.new_window = sat32({96'd0, mdl_base} + mdl_probe);
		e.slow_start_threshold = thr;
		e.congestion_level = cong_level();
		return e;
	endfunction

	function automatic req_t mk_req(logic [1:0] k, logic [23:0] rtt, logic [15:0] segs,
			logic [31:0] cwnd, logic [39:0] bw);
		req_t r;
		r.req_type = k;
		r.rtt_us = rtt;
		r.segments_acked = segs;
		r.current_window = cwnd;
		r.bandwidth_estimate = bw;
		return r;
	endfunction

	// mostly plausible traffic, some full-range noise
	function automatic req_t rand_req();
		req_t r;
		int   sel;
		sel = $urandom_range(99);
		r.req_type = 2'($urandom);
		r.rtt_us = 24'($urandom);
		r.segments_acked = 16'($urandom);
		r.current_window = $urandom;
		r.bandwidth_estimate = 40'({$urandom, $urandom});
		if (sel < 10) return r;
		r.req_type = (sel < 40) ? REQ_RTT : (sel < 82) ? REQ_ACK : (sel < 96) ? REQ_LOSS : REQ_NOP;
		if ($urandom_range(3) != 0) r.rtt_us = 24'(1000 + $urandom_range(20000));
		if ($urandom_range(19) == 0) r.rtt_us = 24'd0;
		if ($urandom_range(9) != 0) r.segments_acked = 16'($urandom_range(1, 64));
		if ($urandom_range(2) != 0) r.current_window = $urandom_range(1000, 2000000);
		if ($urandom_range(29) == 0) r.current_window = 32'd0;
		if ($urandom_range(2) != 0) r.bandwidth_estimate = 40'($urandom_range(100000000));
		return r;
	endfunction

	task automatic cfg_write(logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(REG_MSS) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mdl_mss = value[13:0];
	endtask

	task automatic drain();
		wait (pend_req.size() == 0 && !in_valid && window_exp.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fired)) begin
			if (pend_req.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
				in_data <= pend_req.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 19);
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		in_fired = in_valid && in_ready;
		if (in_fired) window_exp.push_back(predict_window(in_data));
		if (out_valid && out_ready) begin
			if (window_exp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", out_data);
			end else begin
				e = window_exp.pop_front();
				if (out_data.event_kind !== e.event_kind
						|| out_data.new_window !== e.new_window
						|| out_data.slow_start_threshold !== e.slow_start_threshold
						|| out_data.congestion_level !== e.congestion_level) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_data);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [13:0] mss_set [6];
		mss_set = '{14'd1, 14'd9000, 14'd0, 14'd16383, 14'd1460, 14'd536};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		in_fired = 1'b0;
		calm = 1'b0;
		hold_cycles = 0;
		mismatches = 0;
		build_exp_rom();
		mdl_mss = MSS_RESET;
		mdl_min_rtt = '0;
		mdl_cur_rtt = '0;
		mdl_cong_rtt = '0;
		mdl_base = '0;
		mdl_probe = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty state, zero and extreme fields, every kind
		pend_req.push_back(mk_req(REQ_NOP, 24'd0, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_LOSS, 24'd0, 16'd0, 32'hFFFF_FFFF, 40'd0));
		pend_req.push_back(mk_req(REQ_RTT, 24'd0, 16'hFFFF, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'd0, 32'd5000, 40'd1000));
		pend_req.push_back(mk_req(REQ_RTT, 24'd2000, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_RTT, 24'd1000, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'd1, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'hFFFF, 32'hFFFF_FFFF,
			40'hFF_FFFF_FFFF));
		pend_req.push_back(mk_req(REQ_LOSS, 24'd0, 16'd0, 32'd100000, 40'd0));
		pend_req.push_back(mk_req(REQ_RTT, 24'd1500, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'd3, 32'd20000, 40'd1000000000));
		pend_req.push_back(mk_req(REQ_RTT, 24'd3000, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'd3, 32'd20000, 40'd1000000000));
		pend_req.push_back(mk_req(REQ_LOSS, 24'hFF_FFFF, 16'd0, 32'd1, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'd1, 32'd1, 40'hFF_FFFF_FFFF));
		pend_req.push_back(mk_req(REQ_RTT, 24'hFF_FFFF, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_ACK, 24'd0, 16'd1, 32'd40000, 40'd50000000));
		pend_req.push_back(mk_req(REQ_LOSS, 24'd0, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_RTT, 24'd1, 16'd0, 32'd0, 40'd0));
		pend_req.push_back(mk_req(REQ_NOP, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
			40'hFF_FFFF_FFFF));
		drain();

		foreach (mss_set[p]) begin
			cfg_write({18'd0, mss_set[p]});
			calm = (p == 4);
			for (int n = 0; n < 280; n++) pend_req.push_back(rand_req());
			// starve the output so the request side backs up
			if (p == 1) hold_cycles = 3000;
			drain();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
